/* rtl/mmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants of the matrix max-flow engine.
// Holds widths, operation and register codes, controller states, the
// command and status structs between controller and datapath, and the
// search queue entry layout.
// ----------------------------------------------------------------------------
package mmf_pkg;

  localparam int NODE_W     = 6;
  localparam int MAX_NODES  = 1 << NODE_W;
  localparam int CNT_W      = NODE_W + 1;
  localparam int ADDR_W     = 2 * NODE_W;
  localparam int CELL_DEPTH = 1 << ADDR_W;
  localparam int CELL_W     = 25;
  localparam int CAP_W      = 23;
  localparam int FLOW_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CAP_W-1:0]  PATH_CAP_LIMIT = 23'h7f7f7f;
  localparam logic [CELL_W-1:0] CELL_MAX       = {CELL_W{1'b1}};

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_INIT,
    ST_DEQ_RD,
    ST_DEQ,
    ST_SCAN,
    ST_AUG_PRED,
    ST_AUG_FWD,
    ST_AUG_BACK,
    ST_AUG_WB,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLR_START,
    DP_CLR,
    DP_RUN_START,
    DP_REPORT_BAD,
    DP_INIT,
    DP_DEQ_RD,
    DP_DEQ,
    DP_SCAN,
    DP_AUG_PRED,
    DP_AUG_FWD,
    DP_AUG_BACK,
    DP_AUG_WB,
    DP_REPORT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic terms_equal;
    logic q_empty;
    logic head_is_sink;
    logic scan_done;
    logic at_source;
  } dp_stat_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [CAP_W-1:0]  bn;
  } q_entry_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_count;
    logic [NODE_W-1:0] source;
    logic [NODE_W-1:0] sink;
  } cfg_t;

endpackage

/* rtl/matrix_max_flow_engine.sv */
`timescale 1ns / 1ps
// A clear writes zero to all 4096 matrix cells; loads may follow back to back.
// A run repeats breadth-first searches, each dequeuing nodes and scanning their neighbors,
// and augments each path found edge by edge through the single read port of the matrix RAM.
// The run result strobes out_valid, registered after the done state that ends the final, empty search; no stalls.
// Reset is synchronous; after reset the block is busy while it clears the whole matrix.
// ----------------------------------------------------------------------------
// matrix_max_flow_engine: Edmonds-Karp maximum flow engine.
// Holds the configuration registers and joins the controller and datapath.
// ----------------------------------------------------------------------------
module matrix_max_flow_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_operation,
  input  logic [mmf_pkg::NODE_W-1:0]         in_from_node,
  input  logic [mmf_pkg::NODE_W-1:0]         in_to_node,
  input  logic [mmf_pkg::CAP_W-1:0]          in_capacity,
  output logic                               out_valid,
  output logic [mmf_pkg::FLOW_W-1:0]         out_total_flow,
  output logic                               out_bad_terminals,
  input  logic                               cfg_we,
  input  logic [mmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mmf_pkg::NODE_W-1:0]         cfg_wdata
);

  mmf_pkg::cfg_t     cfg_r;
  mmf_pkg::dp_cmd_t  cmd;
  mmf_pkg::dp_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_count <= mmf_pkg::NODE_W'(2);
      cfg_r.source     <= mmf_pkg::NODE_W'(1);
      cfg_r.sink       <= mmf_pkg::NODE_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        mmf_pkg::CFG_NODE_COUNT: cfg_r.node_count <= cfg_wdata;
        mmf_pkg::CFG_SOURCE:     cfg_r.source     <= cfg_wdata;
        mmf_pkg::CFG_SINK:       cfg_r.sink       <= cfg_wdata;
        default:                 cfg_r            <= cfg_r;
      endcase
    end
  end

  mmf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .operation(in_operation),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  mmf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg(cfg_r),
    .from_node(in_from_node), .to_node(in_to_node), .capacity(in_capacity),
    .stat(stat), .out_valid(out_valid), .out_total_flow(out_total_flow),
    .out_bad_terminals(out_bad_terminals)
  );

endmodule

/* rtl/mmf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_ram: generic single-port-write, single-port-read RAM.
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module mmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mmf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_ctrl: controller of the matrix max-flow engine.
// Sequences matrix clearing, cell loads, breadth-first searches and path
// augmentation by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
module mmf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        operation,
  input  mmf_pkg::dp_stat_t stat,
  output mmf_pkg::dp_cmd_t  cmd,
  output logic              busy
);

  mmf_pkg::state_t state_r, state_nxt;

  // State register; reset starts the matrix clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = mmf_pkg::DP_NONE;
    busy      = 1'b1;
    case (state_r)
      mmf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (operation)
            mmf_pkg::OP_CLEAR: begin
              cmd.op    = mmf_pkg::DP_CLR_START;
              state_nxt = mmf_pkg::ST_CLEAR;
            end
            mmf_pkg::OP_LOAD: begin
              cmd.op = mmf_pkg::DP_LOAD;
            end
            mmf_pkg::OP_RUN: begin
              if (stat.terms_equal) begin
                cmd.op = mmf_pkg::DP_REPORT_BAD;
              end else begin
                cmd.op    = mmf_pkg::DP_RUN_START;
                state_nxt = mmf_pkg::ST_INIT;
              end
            end
            default: begin
              cmd.op = mmf_pkg::DP_NONE;
            end
          endcase
        end
      end
      mmf_pkg::ST_CLEAR: begin
        cmd.op = mmf_pkg::DP_CLR;
        if (stat.clr_last) begin
          state_nxt = mmf_pkg::ST_IDLE;
        end
      end
      mmf_pkg::ST_INIT: begin
        cmd.op    = mmf_pkg::DP_INIT;
        state_nxt = mmf_pkg::ST_DEQ_RD;
      end
      mmf_pkg::ST_DEQ_RD: begin
        if (stat.q_empty) begin
          state_nxt = mmf_pkg::ST_DONE;
        end else begin
          cmd.op    = mmf_pkg::DP_DEQ_RD;
          state_nxt = mmf_pkg::ST_DEQ;
        end
      end
      mmf_pkg::ST_DEQ: begin
        cmd.op = mmf_pkg::DP_DEQ;
        if (stat.head_is_sink) begin
          state_nxt = mmf_pkg::ST_AUG_PRED;
        end else begin
          state_nxt = mmf_pkg::ST_SCAN;
        end
      end
      mmf_pkg::ST_SCAN: begin
        cmd.op = mmf_pkg::DP_SCAN;
        if (stat.scan_done) begin
          state_nxt = mmf_pkg::ST_DEQ_RD;
        end
      end
      mmf_pkg::ST_AUG_PRED: begin
        cmd.op    = mmf_pkg::DP_AUG_PRED;
        state_nxt = mmf_pkg::ST_AUG_FWD;
      end
      mmf_pkg::ST_AUG_FWD: begin
        cmd.op    = mmf_pkg::DP_AUG_FWD;
        state_nxt = mmf_pkg::ST_AUG_BACK;
      end
      mmf_pkg::ST_AUG_BACK: begin
        cmd.op    = mmf_pkg::DP_AUG_BACK;
        state_nxt = mmf_pkg::ST_AUG_WB;
      end
      mmf_pkg::ST_AUG_WB: begin
        cmd.op = mmf_pkg::DP_AUG_WB;
        if (stat.at_source) begin
          state_nxt = mmf_pkg::ST_INIT;
        end else begin
          state_nxt = mmf_pkg::ST_AUG_PRED;
        end
      end
      mmf_pkg::ST_DONE: begin
        cmd.op    = mmf_pkg::DP_REPORT;
        state_nxt = mmf_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mmf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmf_dp: datapath of the matrix max-flow engine.
// Holds the residual matrix, search queue and predecessor memories, the
// visited flags, search counters, flow accumulator and result registers.
// ----------------------------------------------------------------------------
module mmf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mmf_pkg::dp_cmd_t             cmd,
  input  mmf_pkg::cfg_t                cfg,
  input  logic [mmf_pkg::NODE_W-1:0]   from_node,
  input  logic [mmf_pkg::NODE_W-1:0]   to_node,
  input  logic [mmf_pkg::CAP_W-1:0]    capacity,
  output mmf_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  output logic [mmf_pkg::FLOW_W-1:0]   out_total_flow,
  output logic                         out_bad_terminals
);

  localparam int NW = mmf_pkg::NODE_W;
  localparam int CW = mmf_pkg::CNT_W;

  // Memory ports.
  logic                        m_we;
  logic [mmf_pkg::ADDR_W-1:0]  m_waddr, m_raddr;
  logic [mmf_pkg::CELL_W-1:0]  m_wdata, m_rdata;
  logic                        q_we;
  logic [NW-1:0]               q_waddr;
  mmf_pkg::q_entry_t           q_wdata, q_rdata;
  logic                        p_we;
  logic [NW-1:0]               p_waddr;
  logic [NW-1:0]               p_rdata;

  // Control registers.
  logic [mmf_pkg::ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               tail_r, tail_nxt;
  logic [CW-1:0]               v_r, v_nxt;
  logic                        pend_r, pend_nxt;
  logic [mmf_pkg::MAX_NODES-1:0] visited_r, visited_nxt;
  logic                        out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [NW-1:0]               pend_v_r, pend_v_nxt;
  logic [NW-1:0]               u_r, u_nxt;
  logic [mmf_pkg::CAP_W-1:0]   bn_r, bn_nxt;
  logic [NW-1:0]               j_r, j_nxt;
  logic [NW-1:0]               p_r, p_nxt;
  logic [mmf_pkg::FLOW_W-1:0]  flow_r, flow_nxt;
  logic [mmf_pkg::FLOW_W-1:0]  out_flow_r, out_flow_nxt;
  logic                        out_bad_r, out_bad_nxt;

  // Helpers.
  logic [CW-1:0]               last;
  logic                        issue;
  logic                        hit;
  logic [mmf_pkg::CAP_W-1:0]   bn_hit;
  logic [mmf_pkg::CELL_W:0]    back_sum;
  logic [mmf_pkg::FLOW_W:0]    flow_sum;

  mmf_ram #(.WIDTH(mmf_pkg::CELL_W), .DEPTH(mmf_pkg::CELL_DEPTH)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  mmf_ram #(.WIDTH($bits(mmf_pkg::q_entry_t)), .DEPTH(mmf_pkg::MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(head_r[NW-1:0]), .rdata(q_rdata)
  );

  mmf_ram #(.WIDTH(NW), .DEPTH(mmf_pkg::MAX_NODES)) u_pred (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(u_r),
    .raddr(j_r), .rdata(p_rdata)
  );

  // Highest scanned neighbor, clamped to the node range.
  always_comb begin
    if ({1'b0, cfg.node_count} < CW'(mmf_pkg::MAX_NODES)) begin
      last = {1'b0, cfg.node_count};
    end else begin
      last = CW'(mmf_pkg::MAX_NODES - 1);
    end
  end

  // Scan helpers: neighbor issue and acceptance of the returning cell.
  assign issue    = (cmd.op == mmf_pkg::DP_SCAN) && (v_r <= last);
  assign hit      = (cmd.op == mmf_pkg::DP_SCAN) && pend_r && (m_rdata != '0) &&
                    !visited_r[pend_v_r] && (tail_r < CW'(mmf_pkg::MAX_NODES));
  assign bn_hit   = ({2'b00, bn_r} < m_rdata) ? bn_r : m_rdata[mmf_pkg::CAP_W-1:0];
  assign back_sum = {1'b0, m_rdata} + {3'b000, bn_r};
  assign flow_sum = {1'b0, flow_r} + {10'd0, bn_r};

  // Status toward the controller.
  always_comb begin
    stat.clr_last     = (clr_cnt_r == '1);
    stat.terms_equal  = (cfg.source == cfg.sink);
    stat.q_empty      = (head_r == tail_r);
    stat.head_is_sink = (q_rdata.node == cfg.sink);
    stat.scan_done    = (v_r > last) && !pend_r;
    stat.at_source    = (p_r == cfg.source);
  end

  // Datapath actions per command.
  always_comb begin
    m_we          = 1'b0;
    m_waddr       = {from_node, to_node};
    m_wdata       = {2'b00, capacity};
    m_raddr       = {u_r, v_r[NW-1:0]};
    q_we          = hit;
    q_waddr       = tail_r[NW-1:0];
    q_wdata       = '{node: pend_v_r, bn: bn_hit};
    p_we          = hit;
    p_waddr       = pend_v_r;
    clr_cnt_nxt   = clr_cnt_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r + CW'(hit);
    v_nxt         = v_r;
    pend_nxt      = 1'b0;
    pend_v_nxt    = pend_v_r;
    visited_nxt   = visited_r;
    u_nxt         = u_r;
    bn_nxt        = bn_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    flow_nxt      = flow_r;
    out_valid_nxt = 1'b0;
    out_flow_nxt  = out_flow_r;
    out_bad_nxt   = out_bad_r;
    if (hit) begin
      visited_nxt[pend_v_r] = 1'b1;
    end
    case (cmd.op)
      mmf_pkg::DP_LOAD: begin
        m_we = 1'b1;
      end
      mmf_pkg::DP_CLR_START: begin
        clr_cnt_nxt = '0;
      end
      mmf_pkg::DP_CLR: begin
        m_we        = 1'b1;
        m_waddr     = clr_cnt_r;
        m_wdata     = '0;
        clr_cnt_nxt = clr_cnt_r + mmf_pkg::ADDR_W'(1);
      end
      mmf_pkg::DP_RUN_START: begin
        flow_nxt = '0;
      end
      mmf_pkg::DP_REPORT_BAD: begin
        out_valid_nxt = 1'b1;
        out_flow_nxt  = '0;
        out_bad_nxt   = 1'b1;
      end
      mmf_pkg::DP_INIT: begin
        visited_nxt             = '0;
        visited_nxt[cfg.source] = 1'b1;
        q_we                    = 1'b1;
        q_waddr                 = '0;
        q_wdata                 = '{node: cfg.source, bn: mmf_pkg::PATH_CAP_LIMIT};
        head_nxt                = '0;
        tail_nxt                = CW'(1);
      end
      mmf_pkg::DP_DEQ_RD: begin
        head_nxt = head_r + CW'(1);
      end
      mmf_pkg::DP_DEQ: begin
        u_nxt  = q_rdata.node;
        bn_nxt = q_rdata.bn;
        v_nxt  = CW'(1);
        j_nxt  = cfg.sink;
      end
      mmf_pkg::DP_SCAN: begin
        pend_nxt   = issue;
        pend_v_nxt = v_r[NW-1:0];
        v_nxt      = v_r + CW'(issue);
      end
      mmf_pkg::DP_AUG_FWD: begin
        p_nxt   = p_rdata;
        m_raddr = {p_rdata, j_r};
      end
      mmf_pkg::DP_AUG_BACK: begin
        m_we    = 1'b1;
        m_waddr = {p_r, j_r};
        m_wdata = m_rdata - {2'b00, bn_r};
        m_raddr = {j_r, p_r};
      end
      mmf_pkg::DP_AUG_WB: begin
        m_we    = 1'b1;
        m_waddr = {j_r, p_r};
        m_wdata = back_sum[mmf_pkg::CELL_W] ? mmf_pkg::CELL_MAX :
                  back_sum[mmf_pkg::CELL_W-1:0];
        j_nxt   = p_r;
        if (p_r == cfg.source) begin
          flow_nxt = flow_sum[mmf_pkg::FLOW_W] ? '1 : flow_sum[mmf_pkg::FLOW_W-1:0];
        end
      end
      mmf_pkg::DP_REPORT: begin
        out_valid_nxt = 1'b1;
        out_flow_nxt  = flow_r;
        out_bad_nxt   = 1'b0;
      end
      default: begin
        m_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      v_r         <= '0;
      pend_r      <= 1'b0;
      visited_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      v_r         <= v_nxt;
      pend_r      <= pend_nxt;
      visited_r   <= visited_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_v_r   <= pend_v_nxt;
    u_r        <= u_nxt;
    bn_r       <= bn_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    flow_r     <= flow_nxt;
    out_flow_r <= out_flow_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_total_flow    = out_flow_r;
  assign out_bad_terminals = out_bad_r;

  // The dequeue pointer never passes the enqueue pointer.
  assert property (@(posedge clk) disable iff (!rst_n) head_r <= tail_r)
    else $error("queue head passed tail");

  // The queue never holds more entries than there are nodes.
  assert property (@(posedge clk) disable iff (!rst_n)
                   tail_r <= CW'(mmf_pkg::MAX_NODES))
    else $error("queue overflow");

  // A pending matrix read only follows a scan cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
                   pend_r |-> $past(cmd.op == mmf_pkg::DP_SCAN))
    else $error("pending scan read without scan");

  // A result strobe follows a report command.
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r |-> $past(cmd.op == mmf_pkg::DP_REPORT ||
                                         cmd.op == mmf_pkg::DP_REPORT_BAD))
    else $error("result strobe without report");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the matrix max-flow engine.
// Drives clear, load and run transactions through the start/busy port,
// keeps its own copy of the residual matrix and computes the expected
// Edmonds-Karp flow of every run. Each out_valid strobe is checked against
// the oldest expected flow. A short directed table comes first, then random
// phases under several node count, source and sink settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NODE_W    = mmf_pkg::NODE_W;
  localparam int CAP_W     = mmf_pkg::CAP_W;
  localparam int FLOW_W    = mmf_pkg::FLOW_W;
  localparam int CFG_IDX_W = mmf_pkg::CFG_IDX_W;
  localparam int MAX_NODES = mmf_pkg::MAX_NODES;

  localparam int unsigned     CAP_LIMIT  = 32'(mmf_pkg::PATH_CAP_LIMIT);
  localparam longint unsigned CELL_LIMIT = 64'(mmf_pkg::CELL_MAX);

  localparam logic [1:0] OP_CLEAR  = mmf_pkg::OP_CLEAR;
  localparam logic [1:0] OP_LOAD   = mmf_pkg::OP_LOAD;
  localparam logic [1:0] OP_RUN    = mmf_pkg::OP_RUN;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        op;
    logic [NODE_W-1:0] from_n;
    logic [NODE_W-1:0] to_n;
    logic [CAP_W-1:0]  cap;
    bit                typed;
    logic [FLOW_W-1:0] flow;
    logic              bad;
  } stim_row_t;

  typedef struct {
    logic [FLOW_W-1:0] flow;
    logic              bad;
  } flow_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_operation;
  logic [NODE_W-1:0]    in_from_node;
  logic [NODE_W-1:0]    in_to_node;
  logic [CAP_W-1:0]     in_capacity;
  logic                 out_valid;
  logic [FLOW_W-1:0]    out_total_flow;
  logic                 out_bad_terminals;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [NODE_W-1:0]    cfg_wdata;

  matrix_max_flow_engine u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .in_capacity       (in_capacity),
    .out_valid         (out_valid),
    .out_total_flow    (out_total_flow),
    .out_bad_terminals (out_bad_terminals),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // Model state: residual capacities, search scratch and configuration.
  int unsigned  resid [MAX_NODES][MAX_NODES];
  int unsigned  pred_node [MAX_NODES];
  bit           seen [MAX_NODES];
  int unsigned  bneck [MAX_NODES];
  int unsigned  bfs_q [MAX_NODES];
  int unsigned  m_node_count;
  int unsigned  m_source;
  int unsigned  m_sink;

  flow_result_t flow_expect_q[$];
  int           err_count;
  int           items_sent;

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // One breadth-first search plus augmentation; returns the flow pushed.
  function automatic int unsigned push_one_path(int unsigned src, int unsigned dst,
                                                int unsigned last);
    int unsigned head;
    int unsigned tail;
    int unsigned u;
    int unsigned j;
    int unsigned p;
    int unsigned amount;
    int unsigned steps;
    longint unsigned back;
    head = 0;
    tail = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      pred_node[i] = 127;
      seen[i] = 1'b0;
    end
    bfs_q[tail++] = src;
    seen[src] = 1'b1;
    bneck[src] = CAP_LIMIT;
    while (head < tail) begin
      u = bfs_q[head++];
      if (u == dst) begin
        amount = bneck[dst];
        j = dst;
        steps = 0;
        while (pred_node[j] != 127 && steps < MAX_NODES) begin
          p = pred_node[j];
          back = 64'(resid[j][p]) + 64'(amount);
          resid[p][j] = resid[p][j] - amount;
          resid[j][p] = (back > CELL_LIMIT) ? 32'(CELL_LIMIT) : 32'(back);
          j = p;
          steps++;
        end
        return amount;
      end
      for (int unsigned v = 1; v <= last; v++) begin
        if (resid[u][v] > 0 && !seen[v] && tail < MAX_NODES) begin
          pred_node[v] = u;
          seen[v] = 1'b1;
          bfs_q[tail++] = v;
          bneck[v] = (bneck[u] < resid[u][v]) ? bneck[u] : resid[u][v];
        end
      end
    end
    return 0;
  endfunction

  // Apply one accepted transaction to the model; returns 1 when a run result is due.
  function automatic bit predict_item(logic [1:0] op, logic [NODE_W-1:0] from_n,
                                      logic [NODE_W-1:0] to_n, logic [CAP_W-1:0] cap,
                                      output flow_result_t res);
    longint unsigned total;
    int unsigned last;
    int unsigned d;
    res.flow = '0;
    res.bad  = 1'b0;
    case (op)
      OP_CLEAR: begin
        foreach (resid[r, c]) resid[r][c] = 0;
        return 0;
      end
      OP_LOAD: begin
        resid[from_n][to_n] = 32'(cap);
        return 0;
      end
      OP_RUN: begin
        last = (m_node_count < MAX_NODES) ? m_node_count : 32'(MAX_NODES - 1);
        if (m_source == m_sink) begin
          res.bad = 1'b1;
          return 1;
        end
        total = 0;
        forever begin
          d = push_one_path(m_source, m_sink, last);
          if (d == 0) break;
          total += d;
          if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
        end
        res.flow = total[FLOW_W-1:0];
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Send one transaction, waiting out busy, then record its expected result.
  task automatic send_item(input logic [1:0] op, input logic [NODE_W-1:0] from_n,
                           input logic [NODE_W-1:0] to_n, input logic [CAP_W-1:0] cap,
                           input bit typed, input flow_result_t typed_res);
    int pct;
    int gap;
    flow_result_t res;
    pct = (items_sent < 667) ? 28 : (items_sent < 1333) ? 57 : 0;
    gap = ($urandom_range(0, 99) < pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_from_node <= from_n;
    in_to_node   <= to_n;
    in_capacity  <= cap;
    do @(posedge clk); while (busy);
    items_sent++;
    if (predict_item(op, from_n, to_n, cap, res))
      flow_expect_q.push_back(typed ? typed_res : res);
  endtask

  // Let the block drain before a register write.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (flow_expect_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [NODE_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mmf_pkg::CFG_NODE_COUNT: m_node_count = 32'(val);
      mmf_pkg::CFG_SOURCE:     m_source = 32'(val);
      mmf_pkg::CFG_SINK:       m_sink = 32'(val);
      default: ;
    endcase
  endtask

  // Result checker: every strobe must match the oldest expected flow.
  always @(posedge clk) begin
    flow_result_t exp_res;
    if (rst_n && out_valid) begin
      if (flow_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result flow=%0h bad=%0b",
                                  out_total_flow, out_bad_terminals));
      end else begin
        exp_res = flow_expect_q.pop_front();
        if (out_total_flow !== exp_res.flow)
          report_mismatch($sformatf("total_flow %0h, expected %0h",
                                    out_total_flow, exp_res.flow));
        if (out_bad_terminals !== exp_res.bad)
          report_mismatch($sformatf("bad_terminals %0b, expected %0b",
                                    out_bad_terminals, exp_res.bad));
      end
    end
  end

  // Watchdog against a hung run.
  initial begin
    #(80_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence.
  initial begin
    stim_row_t    rows [20];
    flow_result_t tres;
    int           ph_cfg [10][4];
    int           n_hi;
    int           r;
    logic [1:0]        op;
    logic [NODE_W-1:0] fn;
    logic [NODE_W-1:0] tn;
    logic [CAP_W-1:0]  cap;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_CLEAR;
    in_from_node = '0;
    in_to_node = '0;
    in_capacity = '0;
    cfg_we = 1'b0;
    cfg_index = mmf_pkg::CFG_NODE_COUNT;
    cfg_wdata = '0;
    err_count = 0;
    items_sent = 0;
    m_node_count = 2;
    m_source = 1;
    m_sink = 2;
    foreach (resid[i, j]) resid[i][j] = 0;

    // Directed rows under the reset configuration (2 nodes, 1 to 2).
    rows = '{
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h0,      1'b0},
      '{OP_LOAD,   6'd1,  6'd2,  23'h7fffff,   1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h7fffff, 1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h0,      1'b0},
      '{OP_LOAD,   6'd63, 6'd63, 23'h7fffff,   1'b0, 32'h0,      1'b0},
      '{OP_LOAD,   6'd0,  6'd0,  23'd0,        1'b0, 32'h0,      1'b0},
      '{OP_LOAD,   6'd0,  6'd63, 23'h555555,   1'b0, 32'h0,      1'b0},
      '{OP_LOAD,   6'd63, 6'd0,  23'h2aaaaa,   1'b0, 32'h0,      1'b0},
      '{OP_UNUSED, 6'd1,  6'd2,  23'd5,        1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h0,      1'b0},
      '{OP_LOAD,   6'd1,  6'd2,  23'd1,        1'b0, 32'h0,      1'b0},
      '{OP_LOAD,   6'd2,  6'd1,  23'h400000,   1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h1,      1'b0},
      '{OP_CLEAR,  6'd0,  6'd0,  23'd0,        1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h0,      1'b0},
      '{OP_LOAD,   6'd1,  6'd2,  23'h7f7f7f,   1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b1, 32'h7f7f7f, 1'b0},
      '{OP_LOAD,   6'd1,  6'd2,  23'h7f7f80,   1'b0, 32'h0,      1'b0},
      '{OP_RUN,    6'd0,  6'd0,  23'd0,        1'b0, 32'h0,      1'b0}
    };

    // Phase settings: node count, source, sink, random transactions.
    ph_cfg = '{
      '{5, 1, 5, 300}, '{8, 2, 7, 300}, '{63, 63, 1, 80}, '{0, 1, 2, 100},
      '{1, 0, 1, 100}, '{6, 3, 3, 80},  '{4, 1, 0, 80},   '{4, 2, 9, 80},
      '{7, 7, 1, 400}, '{6, 0, 6, 400}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) begin
      tres.flow = rows[i].flow;
      tres.bad  = rows[i].bad;
      send_item(rows[i].op, rows[i].from_n, rows[i].to_n, rows[i].cap,
                rows[i].typed, tres);
    end

    // Random phases, each under its own register setting.
    tres.flow = '0;
    tres.bad  = 1'b0;
    foreach (ph_cfg[p]) begin
      wait_idle();
      write_cfg(mmf_pkg::CFG_NODE_COUNT, NODE_W'(ph_cfg[p][0]));
      write_cfg(mmf_pkg::CFG_SOURCE, NODE_W'(ph_cfg[p][1]));
      write_cfg(mmf_pkg::CFG_SINK, NODE_W'(ph_cfg[p][2]));
      n_hi = (ph_cfg[p][0] + 1 > 63) ? 63 : ph_cfg[p][0] + 1;
      send_item(OP_CLEAR, '0, '0, '0, 1'b0, tres);
      for (int k = 0; k < ph_cfg[p][3]; k++) begin
        r = $urandom_range(0, 99);
        op = (r < 80) ? OP_LOAD : (r < 91) ? OP_RUN : (r < 93) ? OP_CLEAR : OP_UNUSED;
        if ($urandom_range(0, 99) < 85) begin
          fn = NODE_W'($urandom_range(0, n_hi));
          tn = NODE_W'($urandom_range(0, n_hi));
        end else begin
          fn = NODE_W'($urandom_range(0, 63));
          tn = NODE_W'($urandom_range(0, 63));
        end
        r = $urandom_range(0, 99);
        cap = (r < 20) ? '0 : (r < 40) ? CAP_W'($urandom_range(1, 15)) :
              (r < 50) ? {CAP_W{1'b1}} : CAP_W'($urandom);
        send_item(op, fn, tn, cap, 1'b0, tres);
      end
    end

    // Drain and give any stray strobe time to show up.
    wait_idle();
    repeat (20) @(posedge clk);
    if (flow_expect_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                flow_expect_q.size()));
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
